@@ rtl/b64e_pkg.sv @@
// b64e_pkg: shared types, constants and the sextet-to-character function
// of the base64 stream encoder; depends on nothing
`default_nettype none

package b64e_pkg;

	// depth of the group queue between front and back
	localparam int unsigned FIFO_DEPTH = 2;

	// ascii codes
	localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;   // '+'
	localparam logic [7:0] SLASH_CHAR = 8'h2F;   // '/'
	localparam logic [7:0] UPPER_A    = 8'h41;   // 'A'
	localparam logic [7:0] LOWER_A    = 8'h61;   // 'a'
	localparam logic [7:0] DIGIT_0    = 8'h30;   // '0'

	localparam logic [5:0] SEXTET_MASK = 6'h3F;

	// number of data sextets in a group, the rest are padding
	localparam logic [2:0] NVALID_ONE_BYTE  = 3'd2;
	localparam logic [2:0] NVALID_TWO_BYTES = 3'd3;
	localparam logic [2:0] NVALID_FULL      = 3'd4;

	// one 24-bit group ready for character output
	typedef struct packed {
		logic [23:0] bits;     // first byte in bits 23..16
		logic [2:0]  nvalid;   // data sextets, 2 to 4
		logic        last;     // last group of the message
	} group_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic valid;
	} fifo_status_t;

	function automatic logic [7:0] sextet_to_char(input logic [5:0] sx);
		logic [7:0] sx8;
		sx8 = {2'b00, sx & SEXTET_MASK};
		if (sx < 6'd26) begin
			sextet_to_char = 8'(UPPER_A + sx8);
		end else if (sx < 6'd52) begin
			sextet_to_char = 8'(LOWER_A + sx8 - 8'd26);
		end else if (sx < 6'd62) begin
			sextet_to_char = 8'(DIGIT_0 + sx8 - 8'd52);
		end else if (sx == 6'd62) begin
			sextet_to_char = PLUS_CHAR;
		end else begin
			sextet_to_char = SLASH_CHAR;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/b64e_front.sv @@
// b64e_front: accepts input bytes, holds up to two pending bytes and
// forms 24-bit groups for the queue; depends on b64e_pkg
`default_nettype none

module b64e_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,    // in_byte
	input  wire logic                  s_tlast,    // in_last
	input  wire b64e_pkg::fifo_status_t status,
	output logic                       push,
	output b64e_pkg::group_t           group
);

	logic [1:0]  cnt_q;
	logic [15:0] pend_q;
	logic        accept;
	logic        complete;

	assign s_tready = !status.full;
	assign accept   = s_tvalid && s_tready;
	assign complete = (cnt_q == 2'd2) || s_tlast;
	assign push     = accept && complete;

	always_comb begin
		group.last = s_tlast;
		priority if (cnt_q == 2'd2) begin
			group.bits   = {pend_q, s_tdata};
			group.nvalid = b64e_pkg::NVALID_FULL;
		end else if (cnt_q == 2'd1) begin
			group.bits   = {pend_q[15:8], s_tdata, 8'h00};
			group.nvalid = b64e_pkg::NVALID_TWO_BYTES;
		end else begin
			group.bits   = {s_tdata, 16'h0000};
			group.nvalid = b64e_pkg::NVALID_ONE_BYTE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			pend_q <= 16'h0000;
		end else if (accept) begin
			if (complete) begin
				cnt_q  <= 2'd0;
				pend_q <= 16'h0000;
			end else begin
				if (cnt_q == 2'd0) begin
					pend_q <= {s_tdata, 8'h00};
				end else begin
					pend_q[7:0] <= s_tdata;
				end
				cnt_q <= 2'(cnt_q + 2'd1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/b64e_fifo.sv @@
// b64e_fifo: short register queue of groups between front and back;
// depends on b64e_pkg
`default_nettype none

module b64e_fifo #(
	parameter int unsigned DEPTH = b64e_pkg::FIFO_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire b64e_pkg::group_t  wr_data,
	input  wire logic              pop,
	output b64e_pkg::group_t       rd_data,
	output b64e_pkg::fifo_status_t status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64e_pkg::group_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.valid = (count_q != '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && status.valid;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (do_pop && !do_push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/b64e_back.sv @@
// b64e_back: takes groups from the queue and sends four characters per
// group through an output register; depends on b64e_pkg
`default_nettype none

module b64e_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire b64e_pkg::fifo_status_t status,
	input  wire b64e_pkg::group_t       head,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [7:0]                  m_tdata,    // out_char
	output logic                        m_tlast     // out_last
);

	b64e_pkg::group_t cur_q;
	logic             busy_q;
	logic [1:0]       k_q;
	logic             adv;
	logic             emit;
	logic [5:0]       sx;
	logic [7:0]       ch;

	assign adv  = !m_tvalid || m_tready;
	assign emit = adv && busy_q;
	// reload the group register when idle or on its fourth character
	assign pop  = status.valid && (!busy_q || (emit && k_q == 2'd3));

	always_comb begin
		unique case (k_q)
			2'd0: sx = cur_q.bits[23:18];
			2'd1: sx = cur_q.bits[17:12];
			2'd2: sx = cur_q.bits[11:6];
			2'd3: sx = cur_q.bits[5:0];
			default: sx = cur_q.bits[5:0];
		endcase
		ch = ({1'b0, k_q} < cur_q.nvalid) ? b64e_pkg::sextet_to_char(sx)
		                                  : b64e_pkg::PAD_CHAR;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			m_tdata <= ch;
			m_tlast <= cur_q.last && (k_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			k_q      <= 2'd0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid <= busy_q;
			end
			if (emit) begin
				k_q <= 2'(k_q + 2'd1);
			end
			if (pop) begin
				busy_q <= 1'b1;
			end else if (emit && k_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/base64_stream_encoder_top.sv @@
// base64 stream encoder: a group that the closing beat completes passes
// through the queue and the group register to the character output register;
// the back sends one character per cycle while the receiver is ready and
// groups are queued, four per group; bytes that close no group go in
// one per cycle while the group queue has room.
// reset (arst_n low, asynchronous) empties pending bytes, queue and output
`default_nettype none

module base64_stream_encoder_top #(
	parameter int unsigned FIFO_DEPTH = b64e_pkg::FIFO_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input bytes
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // in_byte
	input  wire logic       s_tlast,    // in_last
	// encoded characters
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,    // out_char
	output logic            m_tlast     // out_last
);

	// front to queue
	logic                   push;
	b64e_pkg::group_t       wr_group;
	// queue to back
	logic                   pop;
	b64e_pkg::group_t       head;
	b64e_pkg::fifo_status_t status;

	// front: gathers bytes, builds a group on the third or last byte
	b64e_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.status   (status),
		.push     (push),
		.group    (wr_group)
	);

	// queue: lets the front keep taking bytes while the back drains
	b64e_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_group),
		.pop     (pop),
		.rd_data (head),
		.status  (status)
	);

	// back: maps sextets to characters, padding past the data with '='
	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ tb/b64_stream_checker.sv @@
// b64_stream_checker: watches both stream channels of the base64 encoder,
// predicts the characters for each accepted byte beat and compares them in order
// depends on b64e_pkg for the padding character
module b64_stream_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,    // in_byte
	input  wire logic       s_tlast,    // in_last
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,    // out_char
	input  wire logic       m_tlast,    // out_last
	output int unsigned     fail_count,
	output int unsigned     outstanding
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} enc_char_t;

	enc_char_t   expected_chars[$];
	enc_char_t   want;
	logic [15:0] held_bytes;    // first byte of the group in 15..8
	logic [1:0]  held_count;

	function automatic logic [7:0] sextet_char(input logic [5:0] sx);
		if (sx < 6'd26) begin
			return 8'h41 + {2'b00, sx};
		end else if (sx < 6'd52) begin
			return 8'h61 + {2'b00, sx} - 8'd26;
		end else if (sx < 6'd62) begin
			return 8'h30 + {2'b00, sx} - 8'd52;
		end else if (sx == 6'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	// four characters of a 24-bit group, sextets past the data become padding
	task automatic push_group(input logic [23:0] grp, input int nvalid, input logic is_last);
		enc_char_t c;
		for (int k = 0; k < 4; k++) begin
			c.ch = (k < nvalid) ? sextet_char(grp[23 - 6 * k -: 6]) : b64e_pkg::PAD_CHAR;
			c.last = is_last && (k == 3);
			expected_chars.push_back(c);
		end
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic is_last);
		if (held_count == 2'd2) begin
			push_group({held_bytes, b}, 4, is_last);
			held_bytes = '0;
			held_count = '0;
		end else if (is_last) begin
			if (held_count == 2'd1)
				push_group({held_bytes[15:8], b, 8'h00}, 3, 1'b1);
			else
				push_group({b, 16'h0000}, 2, 1'b1);
			held_bytes = '0;
			held_count = '0;
		end else begin
			if (held_count == 2'd0)
				held_bytes = {b, 8'h00};
			else
				held_bytes[7:0] = b;
			held_count = held_count + 2'd1;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			held_bytes = '0;
			held_count = '0;
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				encode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("char %h last %b with nothing expected",
						m_tdata, m_tlast));
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.ch)
						report_mismatch($sformatf("char %h, wanted %h", m_tdata, want.ch));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b on char %h, wanted %b",
							m_tlast, m_tdata, want.last));
				end
			end
			outstanding <= expected_chars.size();
		end
	end

endmodule

@@ tb/base64_stream_encoder_top_tb.sv @@
// base64_stream_encoder_top_tb: drives byte messages into the encoder with random
// gaps and output stalls; b64_stream_checker predicts and compares the characters
// depends on base64_stream_encoder_top, b64e_pkg and b64_stream_checker
module base64_stream_encoder_top_tb;

	localparam int unsigned CYCLE_LIMIT = 200000;   // far above the slowest correct run
	localparam int unsigned HOLD_CYCLES = 300;      // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 20;      // settle time after the last char

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;     // in_byte
	logic        s_tlast;     // in_last
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;     // out_char
	logic        m_tlast;     // out_last

	int unsigned fail_count;
	int unsigned outstanding;     // characters still owed by the encoder
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned rx_hold_req;     // bumped by the sender to ask for a hold-off
	int unsigned rx_hold_seen;

	base64_stream_encoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	b64_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, counts every cycle from the start
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("base64_stream_encoder_top_tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when the sender asks for one
	initial begin
		m_tready = 1'b0;
		rx_hold_seen = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != rx_hold_seen) begin
				rx_hold_seen++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// one byte beat: random idle cycles first, then hold it until accepted
	task automatic send_beat(input logic [7:0] b, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
	endtask

	// message of random bytes, last flag on the final beat
	task automatic send_message(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_beat(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// stop offering bytes until every predicted char has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// whole messages, mostly short so every tail length shows up often
	task automatic run_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(20, 40);
			else
				len = $urandom_range(1, 9);
			send_message(len);
			sent += len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		rx_hold_req = 0;
		send_idle_pct = 7;
		recv_idle_pct = 55;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one-byte tails (two pads), zero sextets give 'A'
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b1);
		// two-byte tails (one pad)
		send_beat(8'h00, 1'b0);
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b1);
		// full groups closed by the last byte: all 'A', all '/', all '+'
		send_beat(8'h00, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b1);
		send_beat(8'hFB, 1'b0);
		send_beat(8'hEF, 1'b0);
		send_beat(8'hBE, 1'b1);
		// full group followed by a one-byte tail
		send_beat(8'h4D, 1'b0);
		send_beat(8'h61, 1'b0);
		send_beat(8'h6E, 1'b0);
		send_beat(8'h61, 1'b1);
		wait_drained();

		// long output hold-off while a long message keeps coming
		rx_hold_req = rx_hold_req + 1;
		send_message(40);
		wait_drained();

		// sender mostly busy, receiver stalls often
		run_random(110);
		wait_drained();

		// sender idles often, receiver mostly ready
		send_idle_pct = 55;
		recv_idle_pct = 7;
		run_random(110);
		wait_drained();

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(110);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("base64_stream_encoder_top_tb OK");
		end else begin
			$display("base64_stream_encoder_top_tb NOT OK");
		end
		$finish;
	end

endmodule
